>>> sv/ctfp_pkg.sv
package ctfp_pkg;

    localparam int IN_FIELDS        = 4;
    localparam int CHAN_W           = 16;
    localparam int BYTE_W           = 8;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MIN_CHANNELS     = 1;
    localparam int MAX_CHANNELS     = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int PTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAN_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CHAN_W-1:0] CRC_POLY = 16'hA001;

    typedef logic signed [CHAN_W-1:0] t_chan;
    typedef logic [BYTE_W-1:0]        t_byte;

    // channel count held to the supported range
    function automatic int clamp_channels(input int n);
        if (n < MIN_CHANNELS) begin
            return MIN_CHANNELS;
        end
        if (n > MAX_CHANNELS) begin
            return MAX_CHANNELS;
        end
        return n;
    endfunction

    // one byte of crc-16/modbus, reflected, lsb first
    function automatic logic [CHAN_W-1:0] crc_byte(input logic [CHAN_W-1:0] crc,
                                                   input t_byte b);
        logic [CHAN_W-1:0] c;
        c = crc ^ {{(CHAN_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/ctfp_if.sv
interface ctfp_req_if;
    logic            valid;
    logic            ready;
    ctfp_pkg::t_chan channel_zero;
    ctfp_pkg::t_chan channel_one;
    ctfp_pkg::t_chan channel_two;
    ctfp_pkg::t_chan channel_three;

    modport source (output valid, channel_zero, channel_one, channel_two, channel_three,
                    input ready);
    modport sink   (input valid, channel_zero, channel_one, channel_two, channel_three,
                    output ready);
endinterface

interface ctfp_byte_if;
    logic            valid;
    logic            ready;
    ctfp_pkg::t_byte frame_byte;
    logic            last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

>>> sv/crc16_telemetry_frame_packer.sv
// telemetry frame packer with crc-16/modbus trailer
//
// i_req is the request channel: one beat carries four signed 16-bit channel
// values. o_byte is the byte channel: each request yields 2*NUM_CHANNELS+2
// beats (ten at the default), every channel low byte then high byte, then
// the crc low and high byte; last_byte marks the crc high byte.
// channels past the fourth input are sent as zero, unused inputs are dropped
//
// the front stage packs each request into a two-entry queue; the back stage
// pops one frame, shifts out one byte a cycle and folds data bytes into the crc
// path: a request beat goes through the queue, the serialiser registers and
// then the output register; throughput is one byte a cycle while the receiver
// holds ready high, set by the single byte-wide output register
// a request is taken while the back stage is still sending the previous frame
//
// reset (synchronous, active low) empties the queue and drops any frame in
// flight. when the receiver holds ready low the output beat holds, the back
// stage stops and the queue fills; i_req.ready falls once two requests wait
module crc16_telemetry_frame_packer #(
    parameter int NUM_CHANNELS = ctfp_pkg::NUM_CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctfp_req_if.sink     i_req,
    ctfp_byte_if.source  o_byte
);

    // channel count actually used: below one counts as one, above eight as eight
    localparam int CH_N = ctfp_pkg::clamp_channels(NUM_CHANNELS);

    // queue between the two stages, one word per pending frame
    logic                             w_q_valid;
    logic                             w_q_ready;
    logic [CH_N*ctfp_pkg::CHAN_W-1:0] w_q_data;

    // front: request acceptance and channel packing
    ctfp_front #(
        .NUM_CHANNELS (CH_N)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .i_q_ready (w_q_ready)
    );

    // back: byte serialiser, crc and output register
    ctfp_back #(
        .NUM_CHANNELS (CH_N)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_ready (w_q_ready),
        .o_byte    (o_byte)
    );

endmodule

>>> sv/ctfp_front.sv
module ctfp_front #(
    parameter int NUM_CHANNELS = ctfp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ctfp_req_if.sink                               i_req,
    output logic                                   o_q_valid,
    output logic [NUM_CHANNELS*ctfp_pkg::CHAN_W-1:0] o_q_data,
    input  logic                                   i_q_ready
);

    localparam int DATA_W = NUM_CHANNELS * ctfp_pkg::CHAN_W;

    logic [ctfp_pkg::IN_FIELDS-1:0][ctfp_pkg::CHAN_W-1:0] w_in;
    logic [DATA_W-1:0] w_word;

    logic [DATA_W-1:0]          r_mem [ctfp_pkg::QUEUE_DEPTH];
    logic [ctfp_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ctfp_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ctfp_pkg::CNT_W-1:0] r_count, n_count;
    logic                       w_push, w_pop;

    assign w_in = {i_req.channel_three, i_req.channel_two,
                   i_req.channel_one, i_req.channel_zero};

    // pack channels, zero beyond the input fields
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        if (g < ctfp_pkg::IN_FIELDS) begin : g_used
            assign w_word[g*ctfp_pkg::CHAN_W +: ctfp_pkg::CHAN_W] = w_in[g];
        end else begin : g_pad
            assign w_word[g*ctfp_pkg::CHAN_W +: ctfp_pkg::CHAN_W] = '0;
        end
    end

    assign i_req.ready = (r_count != ctfp_pkg::CNT_W'(ctfp_pkg::QUEUE_DEPTH));
    assign o_q_valid   = (r_count != '0);
    assign o_q_data    = r_mem[r_rd_ptr];
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == ctfp_pkg::PTR_W'(ctfp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == ctfp_pkg::PTR_W'(ctfp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

endmodule

>>> sv/ctfp_back.sv
module ctfp_back #(
    parameter int NUM_CHANNELS = ctfp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  logic [NUM_CHANNELS*ctfp_pkg::CHAN_W-1:0] i_q_data,
    output logic                                   o_q_ready,
    ctfp_byte_if.source                            o_byte
);

    localparam int DATA_W    = NUM_CHANNELS * ctfp_pkg::CHAN_W;
    localparam int DATA_LEN  = 2 * NUM_CHANNELS;
    localparam int FRAME_LEN = DATA_LEN + 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    logic                      r_busy, n_busy;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [DATA_W-1:0]         r_data, n_data;
    logic [ctfp_pkg::CHAN_W-1:0] r_crc, n_crc;
    logic                      r_ov, n_ov;
    ctfp_pkg::t_byte           r_ob, n_ob;
    logic                      r_ol, n_ol;

    logic            w_adv, w_is_data, w_is_last, w_load, w_out_free;
    ctfp_pkg::t_byte w_byte;

    assign w_out_free = !r_ov || o_byte.ready;
    assign w_adv      = r_busy && w_out_free;
    assign w_is_data  = (r_idx < IDX_W'(DATA_LEN));
    assign w_is_last  = (r_idx == IDX_W'(FRAME_LEN - 1));
    assign o_q_ready  = !r_busy || (w_adv && w_is_last);
    assign w_load     = i_q_valid && o_q_ready;

    always_comb begin
        if (w_is_data) begin
            w_byte = r_data[ctfp_pkg::BYTE_W-1:0];
        end else if (r_idx == IDX_W'(DATA_LEN)) begin
            w_byte = r_crc[ctfp_pkg::BYTE_W-1:0];
        end else begin
            w_byte = r_crc[ctfp_pkg::CHAN_W-1:ctfp_pkg::BYTE_W];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_data = r_data;
        n_crc  = r_crc;
        n_ov   = r_ov;
        n_ob   = r_ob;
        n_ol   = r_ol;
        if (w_adv) begin
            n_idx  = r_idx + 1'b1;
            n_data = {{ctfp_pkg::BYTE_W{1'b0}}, r_data[DATA_W-1:ctfp_pkg::BYTE_W]};
            if (w_is_data) begin
                n_crc = ctfp_pkg::crc_byte(r_crc, w_byte);
            end
            if (w_is_last) begin
                n_busy = 1'b0;
            end
        end
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_data = i_q_data;
            n_crc  = ctfp_pkg::CRC_INIT;
        end
        if (w_out_free) begin
            n_ov = w_adv;
            n_ob = w_byte;
            n_ol = w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_crc  <= n_crc;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
    end

    assign o_byte.valid      = r_ov;
    assign o_byte.frame_byte = r_ob;
    assign o_byte.last_byte  = r_ol;

endmodule

>>> sv/ctfp_checker.sv
module ctfp_checker #(
    parameter int NUM_CHANNELS = ctfp_pkg::NUM_CHANNELS_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_byte_valid,
    input logic            i_byte_ready,
    input ctfp_pkg::t_byte i_frame_byte,
    input logic            i_last_byte
);

    localparam int CH_N      = ctfp_pkg::clamp_channels(NUM_CHANNELS);
    localparam int FRAME_LEN = 2 * CH_N + 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    logic [IDX_W-1:0] r_pos;
    logic [2:0]       r_pending;
    logic             w_in_beat, w_out_beat, w_frame_end;

    assign w_in_beat   = i_req_valid && i_req_ready;
    assign w_out_beat  = i_byte_valid && i_byte_ready;
    assign w_frame_end = w_out_beat && i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pending <= '0;
        end else begin
            if (w_out_beat) begin
                r_pos <= i_last_byte ? '0 : r_pos + 1'b1;
            end
            if (w_in_beat && !w_frame_end) begin
                r_pending <= r_pending + 1'b1;
            end else if (w_frame_end && !w_in_beat) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_byte_valid)
        else $error("byte valid right after reset");

    // last flag exactly on the final beat of each frame
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid |-> (i_last_byte == (r_pos == IDX_W'(FRAME_LEN - 1))))
        else $error("last flag out of place");

    // no byte without an accepted request behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid |-> (r_pending != '0))
        else $error("byte with no pending request");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && !i_byte_ready |=>
            i_byte_valid && $stable(i_frame_byte) && $stable(i_last_byte))
        else $error("stalled byte changed");

endmodule

bind crc16_telemetry_frame_packer ctfp_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_ctfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_byte_valid (o_byte.valid),
    .i_byte_ready (o_byte.ready),
    .i_frame_byte (o_byte.frame_byte),
    .i_last_byte  (o_byte.last_byte)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // frame length follows the same clamp as the block: 1 to 8 channels
    localparam int NUM_CH       = ctfp_pkg::NUM_CHANNELS_DEF;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        ctfp_pkg::t_byte value;
        logic            last;
    } t_frame_beat;

    logic i_clk;
    logic i_rst_n;

    ctfp_req_if  req_if ();
    ctfp_byte_if byte_if ();

    crc16_telemetry_frame_packer #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_byte  (byte_if)
    );

    // beats still owed by the block, oldest first
    t_frame_beat frame_beats_due [$];

    int idle_pct;
    int stall_pct;
    int frames_sent;
    int beats_checked;
    int mismatch_count;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // fold one byte into the running crc, one bit at a time, lsb first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input ctfp_pkg::t_byte b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ ctfp_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // work out the whole frame for one request and queue its beats
    function automatic void predict_frame(input ctfp_pkg::t_chan c0, input ctfp_pkg::t_chan c1,
                                          input ctfp_pkg::t_chan c2, input ctfp_pkg::t_chan c3);
        ctfp_pkg::t_chan chans [4];
        logic [15:0]     word;
        logic [15:0]     crc;
        ctfp_pkg::t_byte bytes_out [$];
        int              n;
        t_frame_beat     beat;
        chans[0] = c0;
        chans[1] = c1;
        chans[2] = c2;
        chans[3] = c3;
        n = NUM_CH;
        if (n < 1) begin
            n = 1;
        end
        if (n > 8) begin
            n = 8;
        end
        crc = ctfp_pkg::CRC_INIT;
        for (int i = 0; i < n; i++) begin
            // channels past the four inputs go out as zero
            word = (i < ctfp_pkg::IN_FIELDS) ? chans[i] : 16'h0000;
            bytes_out.push_back(word[7:0]);
            bytes_out.push_back(word[15:8]);
            crc = crc_add_byte(crc, word[7:0]);
            crc = crc_add_byte(crc, word[15:8]);
        end
        bytes_out.push_back(crc[7:0]);
        bytes_out.push_back(crc[15:8]);
        foreach (bytes_out[i]) begin
            beat.value = bytes_out[i];
            beat.last  = (i == bytes_out.size() - 1);
            frame_beats_due.push_back(beat);
        end
    endfunction

    // receiver: ready changes on the falling edge, stalling at stall_pct
    always @(negedge i_clk) begin
        byte_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // checker: every accepted output beat against the oldest one owed
    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            if (frame_beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none got byte %02h last %0b",
                         $time, byte_if.frame_byte, byte_if.last_byte);
                mismatch_count++;
            end else begin
                want = frame_beats_due.pop_front();
                beats_checked++;
                if (byte_if.frame_byte !== want.value) begin
                    $display("%0t: frame_byte mismatch, expected %02h got %02h",
                             $time, want.value, byte_if.frame_byte);
                    mismatch_count++;
                end
                if (byte_if.last_byte !== want.last) begin
                    $display("%0t: last_byte mismatch, expected %0b got %0b",
                             $time, want.last, byte_if.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // one request beat; gaps come before it at idle_pct
    task automatic send_request(input ctfp_pkg::t_chan c0, input ctfp_pkg::t_chan c1,
                                input ctfp_pkg::t_chan c2, input ctfp_pkg::t_chan c3);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.channel_zero  <= c0;
        req_if.channel_one   <= c1;
        req_if.channel_two   <= c2;
        req_if.channel_three <= c3;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predict_frame(c0, c1, c2, c3);
        frames_sent++;
    endtask

    // stop sending and let every owed beat come out, plus a margin
    task automatic drain_frames();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (frame_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // half the time corner values, otherwise anything the 16 bits allow
    function automatic ctfp_pkg::t_chan pick_channel();
        case ($urandom_range(7))
            0:       return ctfp_pkg::t_chan'(16'h0000);
            1:       return ctfp_pkg::t_chan'(16'hFFFF);
            2:       return ctfp_pkg::t_chan'(16'h7FFF);
            3:       return ctfp_pkg::t_chan'(16'h8000);
            default: return ctfp_pkg::t_chan'($urandom);
        endcase
    endfunction

    task automatic send_random_frames(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(pick_channel(), pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    // extremes, byte-order patterns and one value moved across each channel slot
    task automatic test_directed_values();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_request(ctfp_pkg::t_chan'(16'h8000), ctfp_pkg::t_chan'(16'h8000),
                     ctfp_pkg::t_chan'(16'h8000), ctfp_pkg::t_chan'(16'h8000));
        send_request(16'sh7FFF, ctfp_pkg::t_chan'(16'h8000),
                     16'sh7FFF, ctfp_pkg::t_chan'(16'h8000));
        send_request(ctfp_pkg::t_chan'(16'h8000), 16'sh7FFF,
                     ctfp_pkg::t_chan'(16'h8000), 16'sh7FFF);
        send_request(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_request(16'sh00FF, ctfp_pkg::t_chan'(16'hFF00),
                     16'sh00FF, ctfp_pkg::t_chan'(16'hFF00));
        send_request(16'sh5555, ctfp_pkg::t_chan'(16'hAAAA),
                     16'sh5555, ctfp_pkg::t_chan'(16'hAAAA));
        send_request(16'sh1234, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(16'sh0000, 16'sh1234, 16'sh0000, 16'sh0000);
        send_request(16'sh0000, 16'sh0000, 16'sh1234, 16'sh0000);
        send_request(16'sh0000, 16'sh0000, 16'sh0000, 16'sh1234);
        // same request twice in a row, back to back
        send_request(16'sh0000, 16'sh0000, 16'sh0000, 16'sh1234);
        drain_frames();
    endtask

    task automatic test_back_to_back();
        idle_pct  = 0;
        stall_pct = 0;
        send_random_frames(104);
        drain_frames();
    endtask

    task automatic test_sender_gaps();
        idle_pct  = 74;
        stall_pct = 0;
        send_random_frames(104);
        drain_frames();
    endtask

    task automatic test_receiver_stalls();
        idle_pct  = 0;
        stall_pct = 74;
        send_random_frames(104);
        drain_frames();
    endtask

    task automatic test_both_idle();
        idle_pct  = 33;
        stall_pct = 33;
        send_random_frames(104);
        drain_frames();
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.channel_zero  = '0;
        req_if.channel_one   = '0;
        req_if.channel_two   = '0;
        req_if.channel_three = '0;
        byte_if.ready        = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        frames_sent          = 0;
        beats_checked        = 0;
        mismatch_count       = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_values();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        $display("sent %0d frame requests (corner values and random) under four idle patterns",
                 frames_sent);
        $display("checked %0d output beats, %0d mismatches", beats_checked, mismatch_count);
        if (mismatch_count == 0 && frame_beats_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d beats still owed", frame_beats_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
